/* src/cod_pkg.sv */
// Shared types and constants for the opcode decoder.
package cod_pkg;

   // Instruction class codes that the decoder names directly or uses as a base.
   localparam logic [5:0] CLS_NOP        = 6'd0;
   localparam logic [5:0] CLS_LD_SP      = 6'd1;
   localparam logic [5:0] CLS_STOP       = 6'd2;
   localparam logic [5:0] CLS_JR_D       = 6'd3;
   localparam logic [5:0] CLS_JR_CC      = 6'd4;
   localparam logic [5:0] CLS_LD_RP      = 6'd5;
   localparam logic [5:0] CLS_ADD_HL     = 6'd6;
   localparam logic [5:0] CLS_LD_BC      = 6'd7;
   localparam logic [5:0] CLS_INC_RP     = 6'd15;
   localparam logic [5:0] CLS_DEC_RP     = 6'd16;
   localparam logic [5:0] CLS_INC_R      = 6'd17;
   localparam logic [5:0] CLS_DEC_R      = 6'd18;
   localparam logic [5:0] CLS_LD_R_N     = 6'd19;
   localparam logic [5:0] CLS_RLCA       = 6'd20;
   localparam logic [5:0] CLS_HALT       = 6'd28;
   localparam logic [5:0] CLS_LD_R_R     = 6'd29;
   localparam logic [5:0] CLS_ALU_R      = 6'd30;
   localparam logic [5:0] CLS_RET_CC     = 6'd31;
   localparam logic [5:0] CLS_LD_HEX_A   = 6'd32;
   localparam logic [5:0] CLS_ADD_SP     = 6'd33;
   localparam logic [5:0] CLS_LD_A_HEX   = 6'd34;
   localparam logic [5:0] CLS_LD_HL_SP   = 6'd35;
   localparam logic [5:0] CLS_POP        = 6'd36;
   localparam logic [5:0] CLS_RET        = 6'd37;
   localparam logic [5:0] CLS_RETI       = 6'd38;
   localparam logic [5:0] CLS_JP_HL      = 6'd39;
   localparam logic [5:0] CLS_LD_SP_HL   = 6'd40;
   localparam logic [5:0] CLS_JP_CC      = 6'd41;
   localparam logic [5:0] CLS_LD_HEXC_A  = 6'd42;
   localparam logic [5:0] CLS_LD_N_A     = 6'd43;
   localparam logic [5:0] CLS_LD_A_HEXC  = 6'd44;
   localparam logic [5:0] CLS_LD_A_N     = 6'd45;
   localparam logic [5:0] CLS_JP         = 6'd46;
   localparam logic [5:0] CLS_CB_PREFIX  = 6'd47;
   localparam logic [5:0] CLS_DI         = 6'd48;
   localparam logic [5:0] CLS_EI         = 6'd49;
   localparam logic [5:0] CLS_CALL_CC    = 6'd50;
   localparam logic [5:0] CLS_PUSH       = 6'd51;
   localparam logic [5:0] CLS_CALL       = 6'd52;
   localparam logic [5:0] CLS_ALU_N      = 6'd53;
   localparam logic [5:0] CLS_RST        = 6'd54;
   localparam logic [5:0] CLS_ROT        = 6'd55;
   localparam logic [5:0] CLS_SET        = 6'd58;

   // Register and pair codes.
   localparam logic [2:0] REG_C      = 3'd1;
   localparam logic [2:0] REG_HL_IND = 3'd6;
   localparam logic [2:0] REG_A      = 3'd7;
   localparam logic [1:0] PAIR_HL    = 2'd2;
   localparam logic [1:0] PAIR_SP    = 2'd3;

   // One decoded instruction.
   typedef struct packed {
      logic [5:0] inst_class;
      logic [1:0] operand_bytes;
      logic [4:0] extra_cycles;
      logic [2:0] reg_first;
      logic [2:0] reg_second;
      logic [1:0] pair_first;
      logic [1:0] pair_second;
      logic [2:0] sub_op;
      logic [1:0] condition;
      logic [5:0] bit_or_vector;
   } dec_type;

endpackage

/* src/cod_decode.sv */
// Combinational decode of one opcode byte into class and operand fields.
module cod_decode (
   input  logic            cmd,
   input  logic [7:0]      opcode,
   output cod_pkg::dec_type dec
);

   logic [1:0] x;
   logic [2:0] y;
   logic [2:0] z;
   logic [1:0] p;
   logic       odd;
   logic [1:0] p_mem;

   assign x     = opcode[7:6];
   assign y     = opcode[5:3];
   assign z     = opcode[2:0];
   assign p     = y[2:1];
   assign odd   = y[0];
   // The HL+ and HL- loads address memory through HL.
   assign p_mem = (p == cod_pkg::PAIR_SP) ? cod_pkg::PAIR_HL : p;

   always_comb begin
      dec = '0;
      dec.inst_class = cod_pkg::CLS_NOP;
      if (cmd) begin
         // CB page: rotate, bit test, reset and set, all on register z.
         dec.inst_class   = 6'(cod_pkg::CLS_ROT + {4'd0, x});
         dec.extra_cycles = 5'd4;
         dec.reg_first    = z;
         if (x == 2'd0) begin
            dec.sub_op = y;
         end else begin
            dec.bit_or_vector = {3'd0, y};
         end
      end else begin
         unique case (x)
            2'd0: begin
               unique case (z)
                  3'd0: begin
                     if (y == 3'd1) begin
                        dec.inst_class    = cod_pkg::CLS_LD_SP;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd16;
                        dec.pair_first    = cod_pkg::PAIR_SP;
                     end else if (y == 3'd2) begin
                        dec.inst_class = cod_pkg::CLS_STOP;
                     end else if (y == 3'd3) begin
                        dec.inst_class    = cod_pkg::CLS_JR_D;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd8;
                     end else if (y[2]) begin
                        dec.inst_class    = cod_pkg::CLS_JR_CC;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd4;
                        dec.condition     = y[1:0];
                     end
                  end
                  3'd1: begin
                     if (!odd) begin
                        dec.inst_class    = cod_pkg::CLS_LD_RP;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd8;
                        dec.pair_first    = p;
                     end else begin
                        dec.inst_class   = cod_pkg::CLS_ADD_HL;
                        dec.extra_cycles = 5'd4;
                        dec.pair_first   = cod_pkg::PAIR_HL;
                        dec.pair_second  = p;
                     end
                  end
                  3'd2: begin
                     // Indirect loads: stores to memory first, then loads into A.
                     dec.inst_class   = 6'(cod_pkg::CLS_LD_BC + {3'd0, odd, p});
                     dec.extra_cycles = 5'd4;
                     if (!odd) begin
                        dec.pair_first = p_mem;
                     end else begin
                        dec.pair_second = p_mem;
                     end
                  end
                  3'd3: begin
                     dec.inst_class   = odd ? cod_pkg::CLS_DEC_RP : cod_pkg::CLS_INC_RP;
                     dec.extra_cycles = 5'd4;
                     dec.pair_first   = p;
                  end
                  3'd4: begin
                     dec.inst_class = cod_pkg::CLS_INC_R;
                     dec.reg_first  = y;
                  end
                  3'd5: begin
                     dec.inst_class = cod_pkg::CLS_DEC_R;
                     dec.reg_first  = y;
                  end
                  3'd6: begin
                     dec.inst_class    = cod_pkg::CLS_LD_R_N;
                     dec.operand_bytes = 2'd1;
                     dec.extra_cycles  = 5'd4;
                     dec.reg_first     = y;
                  end
                  default: begin
                     dec.inst_class = 6'(cod_pkg::CLS_RLCA + {3'd0, y});
                  end
               endcase
            end
            2'd1: begin
               if (y == cod_pkg::REG_HL_IND && z == cod_pkg::REG_HL_IND) begin
                  dec.inst_class = cod_pkg::CLS_HALT;
               end else begin
                  dec.inst_class   = cod_pkg::CLS_LD_R_R;
                  dec.extra_cycles = (y == cod_pkg::REG_HL_IND || z == cod_pkg::REG_HL_IND)
                                     ? 5'd4 : 5'd0;
                  dec.reg_first    = y;
                  dec.reg_second   = z;
               end
            end
            2'd2: begin
               dec.inst_class   = cod_pkg::CLS_ALU_R;
               dec.extra_cycles = (z == cod_pkg::REG_HL_IND) ? 5'd4 : 5'd0;
               dec.sub_op       = y;
               dec.reg_second   = z;
            end
            default: begin
               unique case (z)
                  3'd0: begin
                     if (!y[2]) begin
                        dec.inst_class   = cod_pkg::CLS_RET_CC;
                        dec.extra_cycles = 5'd4;
                        dec.condition    = y[1:0];
                     end else if (y == 3'd4) begin
                        dec.inst_class    = cod_pkg::CLS_LD_HEX_A;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd8;
                        dec.reg_second    = cod_pkg::REG_A;
                     end else if (y == 3'd5) begin
                        dec.inst_class    = cod_pkg::CLS_ADD_SP;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd12;
                        dec.pair_first    = cod_pkg::PAIR_SP;
                     end else if (y == 3'd6) begin
                        dec.inst_class    = cod_pkg::CLS_LD_A_HEX;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd8;
                        dec.reg_first     = cod_pkg::REG_A;
                     end else begin
                        dec.inst_class    = cod_pkg::CLS_LD_HL_SP;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd8;
                        dec.pair_first    = cod_pkg::PAIR_HL;
                        dec.pair_second   = cod_pkg::PAIR_SP;
                     end
                  end
                  3'd1: begin
                     if (!odd) begin
                        dec.inst_class   = cod_pkg::CLS_POP;
                        dec.extra_cycles = 5'd8;
                        dec.pair_first   = p;
                     end else begin
                        unique case (p)
                           2'd0: begin
                              dec.inst_class   = cod_pkg::CLS_RET;
                              dec.extra_cycles = 5'd12;
                           end
                           2'd1: begin
                              dec.inst_class   = cod_pkg::CLS_RETI;
                              dec.extra_cycles = 5'd12;
                           end
                           2'd2: begin
                              dec.inst_class = cod_pkg::CLS_JP_HL;
                              dec.pair_first = cod_pkg::PAIR_HL;
                           end
                           default: begin
                              dec.inst_class   = cod_pkg::CLS_LD_SP_HL;
                              dec.extra_cycles = 5'd4;
                              dec.pair_first   = cod_pkg::PAIR_SP;
                              dec.pair_second  = cod_pkg::PAIR_HL;
                           end
                        endcase
                     end
                  end
                  3'd2: begin
                     if (!y[2]) begin
                        dec.inst_class    = cod_pkg::CLS_JP_CC;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd8;
                        dec.condition     = y[1:0];
                     end else if (y == 3'd4) begin
                        dec.inst_class   = cod_pkg::CLS_LD_HEXC_A;
                        dec.extra_cycles = 5'd4;
                        dec.reg_first    = cod_pkg::REG_C;
                        dec.reg_second   = cod_pkg::REG_A;
                     end else if (y == 3'd5) begin
                        dec.inst_class    = cod_pkg::CLS_LD_N_A;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd12;
                        dec.reg_second    = cod_pkg::REG_A;
                     end else if (y == 3'd6) begin
                        dec.inst_class   = cod_pkg::CLS_LD_A_HEXC;
                        dec.extra_cycles = 5'd4;
                        dec.reg_first    = cod_pkg::REG_A;
                        dec.reg_second   = cod_pkg::REG_C;
                     end else begin
                        dec.inst_class    = cod_pkg::CLS_LD_A_N;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd12;
                        dec.reg_first     = cod_pkg::REG_A;
                     end
                  end
                  3'd3: begin
                     // Codes not listed here are illegal and stay NOP.
                     if (y == 3'd0) begin
                        dec.inst_class    = cod_pkg::CLS_JP;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd12;
                     end else if (y == 3'd1) begin
                        dec.inst_class    = cod_pkg::CLS_CB_PREFIX;
                        dec.operand_bytes = 2'd1;
                        dec.extra_cycles  = 5'd4;
                     end else if (y == 3'd6) begin
                        dec.inst_class = cod_pkg::CLS_DI;
                     end else if (y == 3'd7) begin
                        dec.inst_class = cod_pkg::CLS_EI;
                     end
                  end
                  3'd4: begin
                     if (!y[2]) begin
                        dec.inst_class    = cod_pkg::CLS_CALL_CC;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd8;
                        dec.condition     = y[1:0];
                     end
                  end
                  3'd5: begin
                     if (!odd) begin
                        dec.inst_class   = cod_pkg::CLS_PUSH;
                        dec.extra_cycles = 5'd12;
                        dec.pair_first   = p;
                     end else if (p == 2'd0) begin
                        dec.inst_class    = cod_pkg::CLS_CALL;
                        dec.operand_bytes = 2'd2;
                        dec.extra_cycles  = 5'd20;
                     end
                  end
                  3'd6: begin
                     dec.inst_class    = cod_pkg::CLS_ALU_N;
                     dec.operand_bytes = 2'd1;
                     dec.extra_cycles  = 5'd4;
                     dec.sub_op        = y;
                  end
                  default: begin
                     dec.inst_class    = cod_pkg::CLS_RST;
                     dec.extra_cycles  = 5'd12;
                     dec.bit_or_vector = {y, 3'd0};
                  end
               endcase
            end
         endcase
      end
   end

endmodule

/* src/cpu_opcode_decoder.sv */
// Opcode decoder top level: input register, decode logic and result register.
// An accepted item is held in the input register, decoded, and then captured in the result register.
// Throughput: one item per cycle; the single decode pass between the two
// registers sets this rate, and stalls on the result side propagate back.
// Reset: synchronous, active high; it clears both valid flags, payload is not reset.
module cpu_opcode_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_opcode,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [5:0] rsp_inst_class,
   output logic [1:0] rsp_operand_bytes,
   output logic [4:0] rsp_extra_cycles,
   output logic [2:0] rsp_reg_first,
   output logic [2:0] rsp_reg_second,
   output logic [1:0] rsp_pair_first,
   output logic [1:0] rsp_pair_second,
   output logic [2:0] rsp_sub_op,
   output logic [1:0] rsp_condition,
   output logic [5:0] rsp_bit_or_vector
);

   logic             in_valid_ff;
   logic             in_valid_in;
   logic             cmd_ff;
   logic [7:0]       opcode_ff;
   logic             out_valid_ff;
   logic             out_valid_in;
   cod_pkg::dec_type out_ff;
   cod_pkg::dec_type dec;
   logic             out_ready;
   logic             in_ready;

   // Each stage takes a new item when it is empty or its item leaves.
   assign out_ready = !out_valid_ff || rsp_ready;
   assign in_ready  = !in_valid_ff || out_ready;
   assign req_ready = in_ready;

   assign in_valid_in  = in_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   cod_decode u_decode (
      .cmd    (cmd_ff),
      .opcode (opcode_ff),
      .dec    (dec)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_ready) begin
         cmd_ff    <= req_cmd;
         opcode_ff <= req_opcode;
      end
      if (out_ready) begin
         out_ff <= dec;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_inst_class    = out_ff.inst_class;
   assign rsp_operand_bytes = out_ff.operand_bytes;
   assign rsp_extra_cycles  = out_ff.extra_cycles;
   assign rsp_reg_first     = out_ff.reg_first;
   assign rsp_reg_second    = out_ff.reg_second;
   assign rsp_pair_first    = out_ff.pair_first;
   assign rsp_pair_second   = out_ff.pair_second;
   assign rsp_sub_op        = out_ff.sub_op;
   assign rsp_condition     = out_ff.condition;
   assign rsp_bit_or_vector = out_ff.bit_or_vector;

   // A held item in the input stage must not change while the result side stalls.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_ready |=> in_valid_ff && $stable(cmd_ff) && $stable(opcode_ff))
      else $error("input stage item changed while stalled");

   // A result leaves only if it was decoded from an item that reached the input stage.
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff && !in_valid_ff |=> !out_valid_ff)
      else $error("result appeared without an item in flight");

   // Class codes stay within the defined range, and the operand byte count is never three.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_ff.inst_class <= cod_pkg::CLS_SET && out_ff.operand_bytes != 2'd3)
      else $error("decoded class or length out of range");

   // Restart vectors are multiples of eight.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.inst_class == cod_pkg::CLS_RST
         |-> out_ff.bit_or_vector[2:0] == 3'd0)
      else $error("restart vector not aligned");

endmodule
